/* src/robin_hood_hash_insert_assert.svh */
// assertion macros shared by the hash insert rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ROBIN_HOOD_HASH_INSERT_ASSERT_SVH
`define ROBIN_HOOD_HASH_INSERT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RHH_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RHH_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* src/rhh_pkg.sv */
// shared types and constants for the robin hood hash insert block
// no dependencies; used by rhh_mod and robin_hood_hash_insert
package rhh_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = 11;
	localparam int OFF_W       = 16;
	localparam int HASH_W      = 16;
	localparam int STATUS_W    = 2;
	localparam int RECIP_W     = HASH_W + 1;

	localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1024);
	// floor(2^16 / effective size at reset)
	localparam logic [RECIP_W-1:0] RECIP_RESET =
		RECIP_W'((1 << HASH_W) / ((TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024));

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;

	typedef struct packed {
		logic [OFF_W-1:0]  off;
		logic [HASH_W-1:0] hash;
	} slot_t;

	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] value;
	} mod_req_t;

	typedef struct packed {
		logic              valid;
		logic              busy;
		logic [ADDR_W-1:0] rem;
	} mod_rsp_t;

endpackage

/* src/robin_hood_hash_insert.sv */
// robin hood hash table insert: top level with slot memory and control
// depends on rhh_pkg, rhh_mod and robin_hood_hash_insert_assert.svh
//
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    string_offset, key_hash
// out       out  out_valid / out_ready  status, slot_index, displaced_count
// cfg       in   cfg_we                 cfg_wdata (table_size)
//
// zero offset goes straight from idle to done; a full table is found by a scan of the whole ring
// insert: home modulo, a scan for a free slot, then a walk from home that reads each occupied
// slot and works out its resident's home, writes the free slot, then done and back to idle
// after reset a clearing pass writes all 1024 slots, with in_ready low
// a table_size write rebuilds the reciprocal, in_ready low meanwhile
// a result waiting on out_ready holds the next item in its done state
`include "robin_hood_hash_insert_assert.svh"

module robin_hood_hash_insert (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rhh_pkg::OFF_W-1:0]     string_offset,
	input  logic [rhh_pkg::HASH_W-1:0]    key_hash,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rhh_pkg::STATUS_W-1:0]  status,
	output logic [rhh_pkg::ADDR_W-1:0]    slot_index,
	output logic [rhh_pkg::ADDR_W-1:0]    displaced_count,
	input  logic                          cfg_we,
	input  logic [rhh_pkg::SIZE_W-1:0]    cfg_wdata
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HOME  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_PRD   = 3'd4;
	localparam logic [2:0] ST_PCHK  = 3'd5;
	localparam logic [2:0] ST_PMOD  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	localparam int AW = rhh_pkg::ADDR_W;
	localparam int SW = rhh_pkg::SIZE_W;

	// next slot with wrap at the effective size
	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a, input logic [SW-1:0] s);
		logic [SW-1:0] n;
		n = SW'(a) + 1'b1;
		return (n == s) ? '0 : n[AW-1:0];
	endfunction

	// control state
	logic [2:0]       state_q;
	logic [AW-1:0]    clr_addr_q;
	logic [SW-1:0]    tsize_q;
	logic             cfg_pend_q;
	logic [SW-1:0]    scan_left_q;
	logic             rvld_q;
	logic             out_valid_q;

	// per-item payload
	logic [rhh_pkg::OFF_W-1:0]    off_q;      // travelling entry
	logic [rhh_pkg::HASH_W-1:0]   hash_q;
	logic [AW-1:0]                idx_q;      // walk position
	logic [AW-1:0]                scan_addr_q;
	logic [SW-1:0]                trav_q;     // probe distance of travelling entry
	logic [AW-1:0]                swaps_q;
	logic [AW-1:0]                placed_q;
	logic                         first_q;
	rhh_pkg::slot_t               res_q;      // resident under inspection
	logic [rhh_pkg::STATUS_W-1:0] res_stat_q;
	logic [rhh_pkg::STATUS_W-1:0] status_q;
	logic [AW-1:0]                slot_q;
	logic [AW-1:0]                disp_q;

	// slot memory, one write and one read port, registered read data
	rhh_pkg::slot_t mem [rhh_pkg::TABLE_DEPTH];
	rhh_pkg::slot_t rd_q;
	logic           mem_we;
	logic           mem_re;
	logic [AW-1:0]  mem_waddr;
	logic [AW-1:0]  mem_raddr;
	rhh_pkg::slot_t mem_wdata;

	rhh_pkg::mod_req_t req;
	rhh_pkg::mod_rsp_t rsp;

	logic [SW-1:0] size_eff;
	logic          in_fire;
	logic          scan_found;
	logic          scan_full;
	logic          rd_empty;
	logic [SW:0]   dib_raw;
	logic [SW:0]   dib_fix;
	logic [AW-1:0] dib;
	logic          do_swap;
	logic          out_load;

	// out-of-range sizes: zero acts as one, above the depth acts as the depth
	always_comb begin
		priority if (tsize_q == '0) begin
			size_eff = SW'(1);
		end else if (tsize_q > SW'(rhh_pkg::TABLE_DEPTH)) begin
			size_eff = SW'(rhh_pkg::TABLE_DEPTH);
		end else begin
			size_eff = tsize_q;
		end
	end

	assign in_ready   = (state_q == ST_IDLE) && !rsp.busy && !cfg_pend_q;
	assign in_fire    = in_valid && in_ready;
	assign rd_empty   = (rd_q.off == '0);
	assign scan_found = rvld_q && rd_empty;
	assign scan_full  = !scan_found && (scan_left_q == '0) && !rvld_q;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// resident's distance from home: (idx - home) mod size
	assign dib_raw = (SW+1)'(idx_q) + (SW+1)'(size_eff) - (SW+1)'(rsp.rem);
	assign dib_fix = (dib_raw >= (SW+1)'(size_eff)) ? dib_raw - (SW+1)'(size_eff) : dib_raw;
	assign dib     = dib_fix[AW-1:0];
	assign do_swap = trav_q > SW'(dib);

	rhh_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.recalc (cfg_pend_q),
		.size   (size_eff),
		.req    (req),
		.rsp    (rsp)
	);

	// memory and modulo requests
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '{off: off_q, hash: hash_q};
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		req       = '{valid: 1'b0, value: hash_q};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				req = '{valid: in_fire && (string_offset != '0), value: key_hash};
			end
			ST_SCAN: begin
				mem_re    = !scan_found && (scan_left_q != '0);
				mem_raddr = scan_addr_q;
			end
			ST_PRD: begin
				mem_re = 1'b1;
			end
			ST_PCHK: begin
				// empty slot ends the walk, else work out the resident's home
				if (rd_empty) begin
					mem_we = 1'b1;
				end else begin
					req = '{valid: 1'b1, value: rd_q.hash};
				end
			end
			ST_PMOD: begin
				mem_we = rsp.valid && do_swap;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			tsize_q     <= rhh_pkg::SIZE_RESET;
			cfg_pend_q  <= 1'b0;
			scan_left_q <= '0;
			rvld_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cfg_pend_q <= cfg_we;
			if (cfg_we) begin
				tsize_q <= cfg_wdata;
			end
			rvld_q <= mem_re && (state_q == ST_SCAN);
			// a new result may replace the one leaving in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(rhh_pkg::TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (string_offset == '0) ? ST_DONE : ST_HOME;
					end
				end
				ST_HOME: begin
					if (rsp.valid) begin
						state_q     <= ST_SCAN;
						scan_left_q <= size_eff;
					end
				end
				ST_SCAN: begin
					// read-only pass: is there an empty slot anywhere in the ring
					if (scan_found) begin
						state_q <= ST_PRD;
					end else if (scan_left_q != '0) begin
						scan_left_q <= scan_left_q - 1'b1;
					end else if (!rvld_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_PRD: begin
					state_q <= ST_PCHK;
				end
				ST_PCHK: begin
					state_q <= rd_empty ? ST_DONE : ST_PMOD;
				end
				ST_PMOD: begin
					if (rsp.valid) begin
						state_q <= ST_PRD;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					off_q      <= string_offset;
					hash_q     <= key_hash;
					res_stat_q <= (string_offset == '0) ? rhh_pkg::STATUS_ZERO : rhh_pkg::STATUS_OK;
					trav_q     <= '0;
					swaps_q    <= '0;
					placed_q   <= '0;
					first_q    <= 1'b1;
				end
			end
			ST_HOME: begin
				if (rsp.valid) begin
					idx_q       <= rsp.rem;
					scan_addr_q <= rsp.rem;
				end
			end
			ST_SCAN: begin
				if (mem_re) begin
					scan_addr_q <= next_slot(scan_addr_q, size_eff);
				end
				if (scan_full) begin
					res_stat_q <= rhh_pkg::STATUS_FULL;
				end
			end
			ST_PCHK: begin
				if (rd_empty) begin
					if (first_q) begin
						placed_q <= idx_q;
					end
				end else begin
					res_q <= rd_q;
				end
			end
			ST_PMOD: begin
				if (rsp.valid) begin
					if (do_swap) begin
						// resident was closer to home: it takes over the walk
						off_q   <= res_q.off;
						hash_q  <= res_q.hash;
						swaps_q <= swaps_q + 1'b1;
						trav_q  <= SW'(dib) + 1'b1;
						if (first_q) begin
							placed_q <= idx_q;
							first_q  <= 1'b0;
						end
					end else begin
						trav_q <= trav_q + 1'b1;
					end
					idx_q <= next_slot(idx_q, size_eff);
				end
			end
			ST_DONE: begin
				if (out_load) begin
					status_q <= res_stat_q;
					slot_q   <= (res_stat_q == rhh_pkg::STATUS_OK) ? placed_q : '0;
					disp_q   <= (res_stat_q == rhh_pkg::STATUS_OK) ? swaps_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign slot_index      = slot_q;
	assign displaced_count = disp_q;

	`RHH_ASSERT_IMP(a_scan_read_only, clk, arst_n, state_q == ST_SCAN, !mem_we,
		"slot write during free-slot scan")
	`RHH_ASSERT_IMP(a_mod_rsp_expected, clk, arst_n, rsp.valid,
		(state_q == ST_HOME) || (state_q == ST_PMOD), "modulo result with no one waiting")
	`RHH_ASSERT_IMP(a_reject_fields_zero, clk, arst_n,
		out_valid && (status != rhh_pkg::STATUS_OK),
		(slot_index == '0) && (displaced_count == '0), "nonzero fields on a failed insert")
	`RHH_ASSERT_NXT(a_zero_offset_done, clk, arst_n, in_fire && (string_offset == '0),
		state_q == ST_DONE, "zero offset did not go straight to done")

endmodule

/* src/rhh_mod.sv */
// hash modulo table size: reciprocal multiply, three stages
// the reciprocal is rebuilt by a bit-serial divider after a size change
// depends on rhh_pkg
module rhh_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      recalc,
	input  logic [rhh_pkg::SIZE_W-1:0] size,
	input  rhh_pkg::mod_req_t          req,
	output rhh_pkg::mod_rsp_t          rsp
);

	localparam int CNT_W  = $clog2(rhh_pkg::RECIP_W);
	localparam int PROD_W = rhh_pkg::HASH_W + rhh_pkg::RECIP_W;
	localparam int MQ_W   = rhh_pkg::HASH_W + rhh_pkg::SIZE_W;

	// reciprocal divider
	logic [rhh_pkg::RECIP_W-1:0] recip_q;
	logic [rhh_pkg::RECIP_W-1:0] div_quo_q;
	logic [rhh_pkg::SIZE_W-1:0]  div_rem_q;
	logic [CNT_W-1:0]            div_cnt_q;
	logic                        div_busy_q;
	logic [rhh_pkg::SIZE_W:0]    div_shift;
	logic [rhh_pkg::SIZE_W:0]    div_sub;
	logic                        div_ge;

	// dividend is 2^16, so only the first step brings in a one
	assign div_shift = {div_rem_q, (div_cnt_q == CNT_W'(rhh_pkg::RECIP_W - 1))};
	assign div_ge    = div_shift >= {1'b0, size};
	assign div_sub   = div_shift - {1'b0, size};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			recip_q    <= rhh_pkg::RECIP_RESET;
		end else if (recalc) begin
			div_busy_q <= 1'b1;
		end else if (div_busy_q) begin
			if (div_cnt_q == '0) begin
				div_busy_q <= 1'b0;
				recip_q    <= {div_quo_q[rhh_pkg::RECIP_W-2:0], div_ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (recalc) begin
			div_cnt_q <= CNT_W'(rhh_pkg::RECIP_W - 1);
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			div_rem_q <= div_ge ? div_sub[rhh_pkg::SIZE_W-1:0] : div_shift[rhh_pkg::SIZE_W-1:0];
			div_quo_q <= {div_quo_q[rhh_pkg::RECIP_W-2:0], div_ge};
		end
	end

	// modulo pipeline
	logic                        v_s1, v_s2, v_s3;
	logic [rhh_pkg::HASH_W-1:0]  h_s1, h_s2;
	logic [PROD_W-1:0]           p_s1;
	logic [rhh_pkg::HASH_W:0]    m_s2;
	logic [rhh_pkg::ADDR_W-1:0]  rem_s3;
	logic [MQ_W-1:0]             mq;
	logic [rhh_pkg::HASH_W:0]    diff;
	logic [rhh_pkg::HASH_W:0]    diff_fix;

	// estimate is low by at most one quotient step
	assign mq       = MQ_W'(p_s1[rhh_pkg::HASH_W +: rhh_pkg::HASH_W]) * MQ_W'(size);
	assign diff     = {1'b0, h_s2} - m_s2;
	assign diff_fix = (diff >= (rhh_pkg::HASH_W+1)'(size)) ?
		diff - (rhh_pkg::HASH_W+1)'(size) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		h_s1   <= req.value;
		p_s1   <= PROD_W'(req.value) * PROD_W'(recip_q);
		h_s2   <= h_s1;
		m_s2   <= mq[rhh_pkg::HASH_W:0];
		rem_s3 <= diff_fix[rhh_pkg::ADDR_W-1:0];
	end

	always_comb begin
		rsp.valid = v_s3;
		rsp.busy  = div_busy_q;
		rsp.rem   = rem_s3;
	end

endmodule

/* sim/testbench.sv */
// testbench for robin_hood_hash_insert: a shadow table predicts each insert result
// depends on rhh_pkg and the robin_hood_hash_insert rtl; no files, no arguments

module testbench;

	// idle cycles with nothing moving before the run is declared hung
	localparam int HANG_LIMIT = 40000;
	// cycles allowed after the last result before a table_size write or the end
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [rhh_pkg::STATUS_W-1:0] status;
		logic [rhh_pkg::ADDR_W-1:0]   slot;
		logic [rhh_pkg::ADDR_W-1:0]   swaps;
	} insert_result_t;

	// shadow copy of the slot memory plus the results still owed by the block
	class hash_table_shadow;
		rhh_pkg::slot_t             slots[rhh_pkg::TABLE_DEPTH];
		logic [rhh_pkg::SIZE_W-1:0] size_reg;
		insert_result_t             pending_inserts[$];
		int unsigned                mismatches;

		function new();
			foreach (slots[i]) slots[i] = '0;
			size_reg = rhh_pkg::SIZE_RESET;
			mismatches = 0;
		endfunction

		function void set_size(logic [rhh_pkg::SIZE_W-1:0] value);
			size_reg = value;
		endfunction

		// size 0 behaves as 1, anything past the memory depth is clamped
		function int unsigned span();
			if (size_reg == '0) return 1;
			if (size_reg > rhh_pkg::TABLE_DEPTH) return rhh_pkg::TABLE_DEPTH;
			return 32'(size_reg);
		endfunction

		function int unsigned pending();
			return pending_inserts.size();
		endfunction

		// robin hood probe on the shadow table for one accepted entry
		function void note_insert(logic [rhh_pkg::OFF_W-1:0] new_off,
				logic [rhh_pkg::HASH_W-1:0] new_hash);
			int unsigned    size, idx, i, trav, dib, swaps, placed;
			bit             found, first;
			rhh_pkg::slot_t mover, resident;
			insert_result_t r;
			size = span();
			r.status = rhh_pkg::STATUS_OK;
			r.slot = '0;
			r.swaps = '0;
			if (new_off == '0) begin
				r.status = rhh_pkg::STATUS_ZERO;
			end else begin
				idx = 32'(new_hash) % size;
				found = 1'b0;
				// a full table is detected before anything moves
				for (i = 0; i < size && !found; i++) begin
					if (slots[(idx + i) % size].off == '0) found = 1'b1;
				end
				if (!found) begin
					r.status = rhh_pkg::STATUS_FULL;
				end else begin
					mover.off = new_off;
					mover.hash = new_hash;
					trav = 0;
					swaps = 0;
					placed = 0;
					first = 1'b1;
					while (slots[idx].off != '0) begin
						resident = slots[idx];
						dib = (idx + size - (32'(resident.hash) % size)) % size;
						if (trav > dib) begin
							slots[idx] = mover;
							if (first) begin
								placed = idx;
								first = 1'b0;
							end
							mover = resident;
							swaps++;
							trav = dib + 1;
						end else begin
							trav++;
						end
						idx = (idx + 1) % size;
					end
					slots[idx] = mover;
					if (first) placed = idx;
					r.slot = rhh_pkg::ADDR_W'(placed);
					r.swaps = rhh_pkg::ADDR_W'(swaps);
				end
			end
			pending_inserts.push_back(r);
		endfunction

		function void check_result(logic [rhh_pkg::STATUS_W-1:0] status,
				logic [rhh_pkg::ADDR_W-1:0] slot, logic [rhh_pkg::ADDR_W-1:0] swaps);
			insert_result_t exp_r;
			if (pending_inserts.size() == 0) begin
				$display("%0t: result with no insert pending: status %0d slot %0d swaps %0d",
					$time, status, slot, swaps);
				mismatches++;
				return;
			end
			exp_r = pending_inserts.pop_front();
			if (status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
				mismatches++;
			end
			if (slot !== exp_r.slot) begin
				$display("%0t: slot_index expected %0d actual %0d", $time, exp_r.slot, slot);
				mismatches++;
			end
			if (swaps !== exp_r.swaps) begin
				$display("%0t: displaced_count expected %0d actual %0d",
					$time, exp_r.swaps, swaps);
				mismatches++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [rhh_pkg::OFF_W-1:0]    string_offset = '0;
	logic [rhh_pkg::HASH_W-1:0]   key_hash = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [rhh_pkg::STATUS_W-1:0] status;
	logic [rhh_pkg::ADDR_W-1:0]   slot_index;
	logic [rhh_pkg::ADDR_W-1:0]   displaced_count;
	logic                         cfg_we = 1'b0;
	logic [rhh_pkg::SIZE_W-1:0]   cfg_wdata = '0;

	hash_table_shadow shadow;

	// sender and receiver each switch between calm stretches and gappy ones
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;
	int unsigned recv_stall = 0;
	int unsigned quiet_cycles = 0;
	logic [rhh_pkg::HASH_W-1:0] last_hash = '0;

	robin_hood_hash_insert u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.string_offset   (string_offset),
		.key_hash        (key_hash),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.slot_index      (slot_index),
		.displaced_count (displaced_count),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, a few long ones, none while calm
	function automatic int unsigned idle_gap(bit calm);
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: check every transfer, then choose out_ready for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.check_result(status, slot_index, displaced_count);
		if ($urandom_range(0, 299) == 0) recv_calm = !recv_calm;
		if (recv_stall > 0) begin
			out_ready <= 1'b0;
			recv_stall--;
		end else begin
			out_ready <= 1'b1;
			recv_stall = idle_gap(recv_calm);
		end
	end

	// hang detector: any transfer or register write restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
			$display("robin_hood_hash_insert verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// hold one entry on the input until the transfer, then maybe leave a gap;
	// valid stays high on return when no gap was chosen
	task automatic send_entry(logic [rhh_pkg::OFF_W-1:0] new_off,
			logic [rhh_pkg::HASH_W-1:0] new_hash);
		int unsigned gap;
		in_valid <= 1'b1;
		string_offset <= new_off;
		key_hash <= new_hash;
		do @(posedge clk); while (!in_ready);
		shadow.note_insert(new_off, new_hash);
		last_hash = new_hash;
		if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
		gap = idle_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and let every owed result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes only happen with the block idle
	task automatic set_table_size(logic [rhh_pkg::SIZE_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.set_size(value);
	endtask

	// offsets: some zero, some all ones, the rest anywhere
	function automatic logic [rhh_pkg::OFF_W-1:0] pick_offset();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4) return '0;
		if (r < 8) return '1;
		return rhh_pkg::OFF_W'($urandom_range(1, 65535));
	endfunction

	// hashes: mostly random, some clustered near the last one to build probe chains,
	// some aliasing the last home slot, some at the bit extremes
	function automatic logic [rhh_pkg::HASH_W-1:0] pick_hash(int unsigned size);
		int unsigned sel, home;
		sel = $urandom_range(0, 9);
		if (sel < 6) return rhh_pkg::HASH_W'($urandom);
		if (sel < 8) return last_hash + rhh_pkg::HASH_W'($urandom_range(0, 3));
		if (sel < 9) begin
			home = 32'(last_hash) % size;
			return rhh_pkg::HASH_W'(home + size * $urandom_range(0, 65535 / size));
		end
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			default: return 16'h7FFF;
		endcase
	endfunction

	task automatic run_phase(logic [rhh_pkg::SIZE_W-1:0] size_value, int unsigned count);
		int unsigned n, size;
		set_table_size(size_value);
		size = shadow.span();
		for (n = 0; n < count; n++) send_entry(pick_offset(), pick_hash(size));
	endtask

	initial begin
		shadow = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset size of 1024; in_ready stays low through the clear
		send_entry(16'h0000, 16'h0000);   // zero offset
		send_entry(16'h0000, 16'hFFFF);   // zero offset, hash all ones
		send_entry(16'h0001, 16'h0000);   // lands in slot 0
		send_entry(16'hFFFF, 16'hFFFF);   // lands in the last slot
		send_entry(16'h0002, 16'h0400);   // same home as slot 0, probes forward
		send_entry(16'h0003, 16'h0800);   // third entry with home 0
		send_entry(16'h0004, 16'h0001);   // home 1, pushed past the home-0 run
		send_entry(16'h0005, 16'h0000);   // farther from home than a resident: swap
		send_entry(16'h0006, 16'h03FF);   // home in the last slot, wraps and swaps at 0
		send_entry(16'h5555, 16'hAAAA);
		send_entry(16'hAAAA, 16'h5555);
		send_entry(16'h8000, 16'h7FFF);

		// one slot in use and it is taken: full table
		set_table_size(11'd1);
		send_entry(16'h0007, 16'h0005);
		send_entry(16'h0000, 16'h0005);   // zero offset wins over full
		// size 0 behaves as 1
		set_table_size(11'd0);
		send_entry(16'h0008, 16'hFFFF);
		set_table_size(11'd2);
		send_entry(16'h0009, 16'h0001);
		// small size after inserts at the full size: residents rehomed on the fly
		set_table_size(11'd7);
		send_entry(16'h000A, 16'h0003);
		send_entry(16'h000B, 16'h000A);
		// above the memory depth clamps to 1024
		set_table_size(11'd2047);
		send_entry(16'h000C, 16'h07FF);
		send_entry(16'h000D, 16'hFC00);
		set_table_size(11'd1025);
		send_entry(16'h000E, 16'h0400);

		// random part: large sizes while the table is still sparse, small ones later
		run_phase(11'd1024, 300);
		run_phase(11'd2047, 200);
		run_phase(11'd700, 150);
		run_phase(11'd1025, 100);
		run_phase(11'd257, 120);
		run_phase(11'd100, 120);
		run_phase(11'd33, 120);
		run_phase(11'd0, 40);
		run_phase(11'd1, 40);
		run_phase(11'd2, 40);
		run_phase(11'd3, 80);
		run_phase(11'd16, 100);
		run_phase(11'd64, 150);
		run_phase(11'd1024, 60);

		drain_results();
		if (shadow.mismatches == 0 && shadow.pending() == 0) begin
			$display("robin_hood_hash_insert verification clean");
		end else begin
			$display("robin_hood_hash_insert verification failed");
		end
		$finish;
	end

endmodule
